>>> hw/rtl/imucf_pkg.sv
// shared types, constants and helper functions of the imu attitude filter
`default_nettype none

package imucf_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STEPS    = 16;

    localparam int XY_W   = 35;
    localparam int Z_W    = 42;
    localparam int ANG_W  = Z_W - (32 - ANGLE_FRAC_BITS);
    localparam int CCNT_W = $clog2(CORDIC_STEPS);

    localparam int DIVD_W = 37 + ANGLE_FRAC_BITS;
    localparam int DIVS_W = 27;
    localparam int DCNT_W = $clog2(DIVD_W);
    localparam int DQ_W   = DIVD_W - 26;

    localparam int PA_W = 18 + 33;
    localparam int PB_W = 18 + ANG_W;
    localparam int BL_W = ((PA_W > PB_W) ? PA_W : PB_W) + 1;

    localparam longint DEN_DT    = 131000000;
    localparam longint HALF_DT   = DEN_DT / 2;
    localparam longint DEN_RATE  = 131;
    localparam longint HALF_RATE = DEN_RATE / 2;
    localparam longint ZRND      = longint'(1) << (31 - ANGLE_FRAC_BITS);

    localparam logic signed [Z_W-1:0] Q32_180 = 42'sd773094113280;

    localparam int DIV_N   = 5;
    localparam int DV_X    = 0;
    localparam int DV_Y    = 1;
    localparam int DV_Z    = 2;
    localparam int DV_R100 = 3;
    localparam int DV_R10  = 4;

    typedef enum logic [1:0] {
        CFG_GYRO_RANGE = 2'd0,
        CFG_ALPHA      = 2'd1,
        CFG_DEADBAND   = 2'd2,
        CFG_READY      = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SQRT,
        S_PSTART,
        S_PITCH,
        S_MULR,
        S_MULP,
        S_UPD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic                   start;
        logic signed [XY_W-1:0] y;
        logic signed [XY_W-1:0] x;
    } t_cordic_req;

    // atan(2^-i) in degrees, Q32
    function automatic logic signed [Z_W-1:0] atan_q32(input logic [4:0] idx);
        case (idx)
            5'd0:    return 42'sd193273528320;
            5'd1:    return 42'sd114096026022;
            5'd2:    return 42'sd60285206653;
            5'd3:    return 42'sd30601712202;
            5'd4:    return 42'sd15360239180;
            5'd5:    return 42'sd7687607525;
            5'd6:    return 42'sd3844741810;
            5'd7:    return 42'sd1922488225;
            5'd8:    return 42'sd961258781;
            5'd9:    return 42'sd480631223;
            5'd10:   return 42'sd240315841;
            5'd11:   return 42'sd120157949;
            5'd12:   return 42'sd60079955;
            5'd13:   return 42'sd30039978;
            5'd14:   return 42'sd15019989;
            5'd15:   return 42'sd7509994;
            5'd16:   return 42'sd3754997;
            5'd17:   return 42'sd1877499;
            5'd18:   return 42'sd938749;
            5'd19:   return 42'sd469375;
            5'd20:   return 42'sd234687;
            5'd21:   return 42'sd117344;
            5'd22:   return 42'sd58672;
            5'd23:   return 42'sd29336;
            default: return '0;
        endcase
    endfunction

    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = 17'(v);
        return e[16] ? 17'(-e) : 17'(e);
    endfunction

    function automatic logic signed [DQ_W:0] apply_sign(input logic neg,
                                                        input logic [DQ_W-1:0] q);
        logic signed [DQ_W:0] s;
        s = $signed({1'b0, q});
        return neg ? -s : s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end else if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    // angle to tenths of a degree, ties away from zero, saturated
    function automatic logic [15:0] angle_x10(input logic signed [31:0] a);
        logic signed [35:0] v;
        logic [35:0]        m;
        logic [35:0]        q;
        v = 36'(a) * 36'sd10;
        m = v[35] ? 36'(-v) : 36'(v);
        q = (m + (36'd1 << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;
        if (v[35]) begin
            return (q >= 36'd32768) ? 16'h8000 : 16'(36'd0 - q);
        end
        return (q > 36'd32767) ? 16'h7FFF : q[15:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/imu_complementary_attitude_top.sv
// top level of the complementary-filter imu attitude estimator
//
// input channel: i_valid / o_stall with one filtered six-axis sample, the
// step time in microseconds and the zero-yaw flag per transfer. o_stall is
// high while a sample is in work, so one sample is processed at a time.
// output channel: o_valid / i_stall with roll, pitch, yaw, yaw rates and the
// ready and still flags. the result sits in an output register, so the next
// sample is taken while an earlier result still waits behind i_stall.
// config channel: i_cfg_valid / o_cfg_ready with register index and data;
// o_cfg_ready is always high, writes belong in idle periods.
// processing: a setup state, then the bit-serial dividers that form the
// gyro increments and rates, a state that sees them done, then the blend,
// update and output load states. the square root and both cordic passes
// run while the dividers work; the next sample waits while a stalled
// output holds a finished result.
// reset: synchronous active low; angles clear, the filter is unseeded and
// config returns to its default values.
`default_nettype none

module imu_complementary_attitude_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_accel_z,
    input  wire logic signed [15:0] i_gyro_x,
    input  wire logic signed [15:0] i_gyro_y,
    input  wire logic signed [15:0] i_gyro_z,
    input  wire logic [19:0]        i_step_us,
    input  wire logic               i_zero_yaw,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_roll_tenths,
    output logic signed [15:0]      o_pitch_tenths,
    output logic signed [15:0]      o_yaw_x10,
    output logic signed [15:0]      o_yaw_rate_x10,
    output logic signed [15:0]      o_yaw_rate_x100,
    output logic [14:0]             o_drift_x100,
    output logic                    o_yaw_settled,
    output logic                    o_yaw_quiet,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);
    import imucf_pkg::*;

    t_state r_state;
    t_state n_state;

    logic        r_gyro_500;
    logic [15:0] r_alpha;
    logic [11:0] r_deadband;
    logic [11:0] r_ready_th;

    logic signed [15:0] r_ax;
    logic signed [15:0] r_ay;
    logic signed [15:0] r_az;
    logic signed [15:0] r_gx;
    logic signed [15:0] r_gy;
    logic signed [15:0] r_gz;
    logic [19:0]        r_dt;
    logic               r_zy;

    logic [63:0] r_sv;
    logic [63:0] r_root;
    logic [63:0] r_bit;
    logic [63:0] sq_t;

    logic signed [ANG_W-1:0] r_roll_meas;
    logic signed [PA_W-1:0]  r_pa;
    logic signed [PB_W-1:0]  r_pb;
    logic signed [31:0]      r_roll_bl;
    logic signed [31:0]      r_roll;
    logic signed [31:0]      r_pitch;
    logic signed [31:0]      r_yaw;
    logic                    r_seeded;

    logic        r_out_valid;
    logic [15:0] r_out_roll;
    logic [15:0] r_out_pitch;
    logic [15:0] r_out_yaw;
    logic [15:0] r_out_rate10;
    logic [15:0] r_out_rate100;
    logic [14:0] r_out_drift;
    logic        r_out_ready;
    logic        r_out_still;

    logic [17:0] gk_x;
    logic [17:0] gk_y;
    logic [17:0] gk_z;
    logic [17:0] gk_ze;
    logic [23:0] m100;
    logic [21:0] m10;
    logic [19:0] db_lim;
    logic [19:0] rd_lim;
    logic        still;
    logic        ready;
    logic [37:0] px;
    logic [37:0] py;
    logic [37:0] pz;
    logic [31:0] ss;

    logic [DIVD_W-1:0] div_num [DIV_N];
    logic [DIVD_W-1:0] div_q   [DIV_N];
    logic [DIV_N-1:0]  div_busy;
    logic              div_start;

    t_cordic_req             cq;
    logic signed [ANG_W-1:0] cordic_ang;
    logic                    cordic_busy;

    logic signed [DQ_W:0]  d_x;
    logic signed [DQ_W:0]  d_y;
    logic signed [DQ_W:0]  d_z;
    logic [16:0]           alpha_c;
    logic [16:0]           beta;
    logic signed [32:0]    sum_sel;
    logic signed [ANG_W-1:0] acc_sel;
    logic signed [BL_W-1:0]  blend;
    logic                    seed;
    logic signed [31:0]      yaw0;
    logic signed [33:0]      yaw_sum;
    logic signed [33:0]      yaw_wr;
    logic signed [33:0]      half;
    logic [16:0]             q100;
    logic [15:0]             q10;
    logic                    out_load;

    // config port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_500 <= 1'b0;
            r_alpha    <= 16'd32113;
            r_deadband <= 12'd30;
            r_ready_th <= 12'd30;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GYRO_RANGE: r_gyro_500 <= i_cfg_data[0];
                CFG_ALPHA:      r_alpha    <= i_cfg_data;
                CFG_DEADBAND:   r_deadband <= i_cfg_data[11:0];
                CFG_READY:      r_ready_th <= i_cfg_data[11:0];
                default:        r_gyro_500 <= r_gyro_500;
            endcase
        end
    end

    // gyro scaling and rate thresholds
    always_comb begin
        gk_x   = r_gyro_500 ? {mag16(r_gx), 1'b0} : {1'b0, mag16(r_gx)};
        gk_y   = r_gyro_500 ? {mag16(r_gy), 1'b0} : {1'b0, mag16(r_gy)};
        gk_z   = r_gyro_500 ? {mag16(r_gz), 1'b0} : {1'b0, mag16(r_gz)};
        m100   = 24'(gk_z) * 24'd100;
        db_lim = 20'(r_deadband) * 20'd131;
        rd_lim = 20'(r_ready_th) * 20'd131;
        still  = m100 < 24'(db_lim);
        ready  = m100 < 24'(rd_lim);
        gk_ze  = still ? '0 : gk_z;
        m10    = 22'(gk_ze) * 22'd10;
        px     = 38'(gk_x) * 38'(r_dt);
        py     = 38'(gk_y) * 38'(r_dt);
        pz     = 38'(gk_ze) * 38'(r_dt);
        ss     = 32'(r_ay) * 32'(r_ay) + 32'(r_az) * 32'(r_az);

        div_num[DV_X]    = (DIVD_W'(px) << ANGLE_FRAC_BITS) + DIVD_W'(HALF_DT);
        div_num[DV_Y]    = (DIVD_W'(py) << ANGLE_FRAC_BITS) + DIVD_W'(HALF_DT);
        div_num[DV_Z]    = (DIVD_W'(pz) << ANGLE_FRAC_BITS) + DIVD_W'(HALF_DT);
        div_num[DV_R100] = DIVD_W'(m100) + DIVD_W'(HALF_RATE);
        div_num[DV_R10]  = DIVD_W'(m10) + DIVD_W'(HALF_RATE);
    end

    for (genvar g = 0; g < DIV_N; g++) begin : g_div
        imucf_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (div_num[g]),
            .i_divisor  ((g >= DV_R100) ? DIVS_W'(DEN_RATE) : DIVS_W'(DEN_DT)),
            .o_quotient (div_q[g]),
            .o_busy     (div_busy[g])
        );
    end

    imucf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cq),
        .o_angle (cordic_ang),
        .o_busy  (cordic_busy)
    );

    // fsm next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_PREP;
            S_PREP:   n_state = S_SQRT;
            S_SQRT:   if (r_bit[0]) n_state = S_PSTART;
            S_PSTART: n_state = S_PITCH;
            S_PITCH:  if (!cordic_busy && (div_busy == '0)) n_state = S_MULR;
            S_MULR:   n_state = S_MULP;
            S_MULP:   n_state = S_UPD;
            S_UPD:    n_state = S_FIN;
            S_FIN:    if (!r_out_valid || !i_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        o_stall   = (r_state != S_IDLE);
        div_start = (r_state == S_PREP);
        out_load  = (r_state == S_FIN) && (!r_out_valid || !i_stall);
        cq.start  = (r_state == S_PREP) || (r_state == S_PSTART);
        if (r_state == S_PREP) begin
            cq.y = XY_W'(r_ay) <<< 16;
            cq.x = XY_W'(r_az) <<< 16;
        end else begin
            cq.y = -(XY_W'(r_ax) <<< 16);
            cq.x = $signed({{(XY_W-33){1'b0}}, r_root[32:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sample capture and square root
    assign sq_t = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_gx <= i_gyro_x;
            r_gy <= i_gyro_y;
            r_gz <= i_gyro_z;
            r_dt <= i_step_us;
            r_zy <= i_zero_yaw;
        end
        if (r_state == S_PREP) begin
            r_sv   <= {ss, 32'd0};
            r_root <= '0;
            r_bit  <= 64'h4000_0000_0000_0000;
        end else if (r_state == S_SQRT) begin
            if (r_sv >= sq_t) begin
                r_sv   <= r_sv - sq_t;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (r_state == S_PSTART) begin
            r_roll_meas <= cordic_ang;
        end
    end

    // blend and yaw integration
    always_comb begin
        d_x     = apply_sign(r_gx[15], div_q[DV_X][DQ_W-1:0]);
        d_y     = apply_sign(r_gy[15], div_q[DV_Y][DQ_W-1:0]);
        d_z     = apply_sign(r_gz[15], div_q[DV_Z][DQ_W-1:0]);
        alpha_c = (r_alpha > 16'd32768) ? 17'd32768 : 17'(r_alpha);
        beta    = 17'd32768 - alpha_c;
        sum_sel = (r_state == S_MULR) ? (33'(r_roll) + 33'(d_x))
                                      : (33'(r_pitch) + 33'(d_y));
        acc_sel = (r_state == S_MULR) ? r_roll_meas : cordic_ang;
        blend   = (BL_W'(r_pa) + BL_W'(r_pb) + BL_W'(16384)) >>> 15;
        seed    = !r_seeded || (r_dt == '0);
        yaw0    = r_zy ? '0 : r_yaw;
        half    = 34'sd180 <<< ANGLE_FRAC_BITS;
        yaw_sum = 34'(yaw0) + 34'(d_z);
        if (yaw_sum > half) begin
            yaw_wr = yaw_sum - (half <<< 1);
        end else if (yaw_sum < -half) begin
            yaw_wr = yaw_sum + (half <<< 1);
        end else begin
            yaw_wr = yaw_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MULR || r_state == S_MULP) begin
            r_pa <= $signed({1'b0, alpha_c}) * sum_sel;
            r_pb <= $signed({1'b0, beta}) * acc_sel;
        end
        if (r_state == S_MULP) begin
            r_roll_bl <= sat32(64'(blend));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll   <= '0;
            r_pitch  <= '0;
            r_yaw    <= '0;
            r_seeded <= 1'b0;
        end else if (r_state == S_UPD) begin
            r_roll   <= seed ? sat32(64'(r_roll_meas)) : r_roll_bl;
            r_pitch  <= seed ? sat32(64'(cordic_ang)) : sat32(64'(blend));
            r_yaw    <= sat32(64'(yaw_wr));
            r_seeded <= 1'b1;
        end
    end

    // output register
    assign q100 = div_q[DV_R100][16:0];
    assign q10  = div_q[DV_R10][15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_roll  <= angle_x10(r_roll);
            r_out_pitch <= angle_x10(r_pitch);
            r_out_yaw   <= angle_x10(r_yaw);
            if (r_gz[15]) begin
                r_out_rate100 <= (q100 >= 17'd32768) ? 16'h8000 : 16'(16'd0 - q100[15:0]);
                r_out_rate10  <= 16'(16'd0 - q10);
            end else begin
                r_out_rate100 <= (q100 > 17'd32767) ? 16'h7FFF : q100[15:0];
                r_out_rate10  <= q10;
            end
            r_out_drift <= (q100 > 17'd32767) ? 15'h7FFF : q100[14:0];
            r_out_ready <= ready;
            r_out_still <= still;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_roll_tenths   = r_out_roll;
    assign o_pitch_tenths  = r_out_pitch;
    assign o_yaw_x10       = r_out_yaw;
    assign o_yaw_rate_x10  = r_out_rate10;
    assign o_yaw_rate_x100 = r_out_rate100;
    assign o_drift_x100    = r_out_drift;
    assign o_yaw_settled   = r_out_ready;
    assign o_yaw_quiet     = r_out_still;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_PREP))
        else $error("accepted sample did not start work");

    a_roll_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PSTART) |-> !cordic_busy)
        else $error("roll cordic still running when pitch starts");

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULR) |-> (!cordic_busy && (div_busy == '0)))
        else $error("blend started before units finished");

    a_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> r_seeded)
        else $error("filter not seeded after update");

    a_still_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_still) |-> (r_out_rate10 == '0))
        else $error("yaw rate nonzero inside deadband");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/imucf_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module imucf_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [imucf_pkg::DIVD_W-1:0]  i_dividend,
    input  wire logic [imucf_pkg::DIVS_W-1:0]  i_divisor,
    output logic      [imucf_pkg::DIVD_W-1:0]  o_quotient,
    output logic                               o_busy
);
    import imucf_pkg::*;

    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_rem;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;

    assign trial = {r_rem, r_quo[DIVD_W-1]};
    assign ge    = trial >= {1'b0, i_divisor};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DCNT_W'(DIVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], ge};
            r_rem <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;

endmodule

`default_nettype wire

>>> hw/rtl/imucf_cordic.sv
// cordic vectoring unit for atan2 in degrees, one rotation per cycle
`default_nettype none

module imucf_cordic (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire imucf_pkg::t_cordic_req             i_req,
    output logic signed [imucf_pkg::ANG_W-1:0]      o_angle,
    output logic                                    o_busy
);
    import imucf_pkg::*;

    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;
    logic [CCNT_W-1:0]      r_i;
    logic                   r_busy;
    logic                   r_zero;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  z_rnd;
    logic signed [Z_W-1:0]  step_ang;

    assign dx       = r_y >>> r_i;
    assign dy       = r_x >>> r_i;
    assign step_ang = atan_q32(5'(r_i));
    assign z_rnd    = r_z + Z_W'(ZRND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_i == CCNT_W'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_zero <= (i_req.x == '0) && (i_req.y == '0);
            if (i_req.x < 0) begin
                r_x <= -i_req.x;
                r_y <= -i_req.y;
                r_z <= (i_req.y >= 0) ? Q32_180 : -Q32_180;
            end else begin
                r_x <= i_req.x;
                r_y <= i_req.y;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + step_ang;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - step_ang;
            end
        end
    end

    assign o_angle = r_zero ? '0 : z_rnd[Z_W-1 -: ANG_W];
    assign o_busy  = r_busy;

endmodule

`default_nettype wire

>>> tb/sv/tb_imu_complementary_attitude_checker.sv
// checker for the imu attitude filter: watches all channels, predicts each result and compares
`timescale 1ns / 1ps

module tb_imu_complementary_attitude_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_accel_z,
    input  wire logic signed [15:0] i_gyro_x,
    input  wire logic signed [15:0] i_gyro_y,
    input  wire logic signed [15:0] i_gyro_z,
    input  wire logic [19:0]        i_step_us,
    input  wire logic               i_zero_yaw,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic signed [15:0] i_roll_tenths,
    input  wire logic signed [15:0] i_pitch_tenths,
    input  wire logic signed [15:0] i_yaw_x10,
    input  wire logic signed [15:0] i_yaw_rate_x10,
    input  wire logic signed [15:0] i_yaw_rate_x100,
    input  wire logic [14:0]        i_drift_x100,
    input  wire logic               i_yaw_settled,
    input  wire logic               i_yaw_quiet,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_result_count
);
    import imucf_pkg::*;

    typedef struct {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [15:0] rate10;
        logic [15:0] rate100;
        logic [14:0] drift;
        logic        ready;
        logic        still;
    } t_attitude;

    localparam longint DEG180_Q32 = 64'sd773094113280;
    localparam longint I32_MIN    = -64'sd2147483648;
    localparam longint I32_MAX    = 64'sd2147483647;

    localparam longint ATAN_DEG_Q32 [24] = '{
        64'sd193273528320, 64'sd114096026022, 64'sd60285206653, 64'sd30601712202,
        64'sd15360239180, 64'sd7687607525, 64'sd3844741810, 64'sd1922488225,
        64'sd961258781, 64'sd480631223, 64'sd240315841, 64'sd120157949,
        64'sd60079955, 64'sd30039978, 64'sd15019989, 64'sd7509994,
        64'sd3754997, 64'sd1877499, 64'sd938749, 64'sd469375,
        64'sd234687, 64'sd117344, 64'sd58672, 64'sd29336
    };

    t_attitude attitude_q[$];

    logic   range_500;
    longint alpha_q15;
    longint deadband_x100;
    longint ready_x100;
    longint roll_q;
    longint pitch_q;
    longint yaw_q;
    logic   is_seeded;
    int     fails;
    int     results;

    assign o_fail_count   = fails;
    assign o_pending      = attitude_q.size();
    assign o_result_count = results;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint div_nearest(longint num, longint den);
        longint m;
        longint q;
        m = num < 0 ? -num : num;
        q = (m + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? DEG180_Q32 : -DEG180_Q32;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += ATAN_DEG_Q32[i];
            end else begin
                x -= dx;
                y += dy;
                z -= ATAN_DEG_Q32[i];
            end
        end
        return round_shift(z, 32 - ANGLE_FRAC_BITS);
    endfunction

    function automatic logic [15:0] tenths(longint a);
        longint v;
        longint q;
        v = a * 10;
        q = ((v < 0 ? -v : v) + (longint'(1) <<< (ANGLE_FRAC_BITS - 1))) >>> ANGLE_FRAC_BITS;
        return 16'(clamp(v < 0 ? -q : q, -32768, 32767));
    endfunction

    function automatic longint gyro_increment(longint g, longint k, longint dt);
        return div_nearest(g * k * dt * (longint'(1) <<< ANGLE_FRAC_BITS), 131000000);
    endfunction

    function automatic longint mix(longint prev, longint d, longint acc, longint a);
        return clamp(round_shift(a * (prev + d) + (32768 - a) * acc, 15), I32_MIN, I32_MAX);
    endfunction

    function automatic t_attitude predict_attitude();
        t_attitude r;
        longint ax, ay, az, gx, gy, gz, dt, k, a, gabs, gz_use;
        longint roll_meas, pitch_meas, half, y;
        longint unsigned ss;
        ax = i_accel_x; ay = i_accel_y; az = i_accel_z;
        gx = i_gyro_x; gy = i_gyro_y; gz = i_gyro_z;
        dt = i_step_us;
        k = range_500 ? 2 : 1;
        a = alpha_q15 > 32768 ? 32768 : alpha_q15;
        gabs = gz < 0 ? -gz : gz;
        r.rate100 = 16'(clamp(div_nearest(gz * 100 * k, 131), -32768, 32767));
        r.drift   = 15'(clamp(div_nearest(gabs * 100 * k, 131), 0, 32767));
        r.ready   = 100 * gabs * k < ready_x100 * 131;
        r.still   = 100 * gabs * k < deadband_x100 * 131;
        gz_use    = r.still ? 0 : gz;
        r.rate10  = 16'(div_nearest(gz_use * 10 * k, 131));

        roll_meas  = vector_angle(ay * 65536, az * 65536);
        ss         = longint'(ay * ay + az * az);
        pitch_meas = vector_angle(-ax * 65536, longint'(int_sqrt(ss << 32)));

        if (!is_seeded || dt == 0) begin
            roll_q    = clamp(roll_meas, I32_MIN, I32_MAX);
            pitch_q   = clamp(pitch_meas, I32_MIN, I32_MAX);
            is_seeded = 1'b1;
        end else begin
            roll_q  = mix(roll_q, gyro_increment(gx, k, dt), roll_meas, a);
            pitch_q = mix(pitch_q, gyro_increment(gy, k, dt), pitch_meas, a);
        end

        if (i_zero_yaw) yaw_q = 0;
        half = longint'(180) <<< ANGLE_FRAC_BITS;
        y = yaw_q + gyro_increment(gz_use, k, dt);
        if (y > half) y -= 2 * half;
        else if (y < -half) y += 2 * half;
        yaw_q = clamp(y, I32_MIN, I32_MAX);

        r.roll  = tenths(roll_q);
        r.pitch = tenths(pitch_q);
        r.yaw   = tenths(yaw_q);
        return r;
    endfunction

    function automatic void compare_field(string name, logic [15:0] e, logic [15:0] a);
        if (e !== a) begin
            $error("%s: expected %0d (0x%h), got %0d (0x%h)", name,
                   $signed(e), e, $signed(a), a);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_attitude e;
        if (!i_rst_n) begin
            range_500     = 1'b0;
            alpha_q15     = 32113;
            deadband_x100 = 30;
            ready_x100    = 30;
            roll_q        = 0;
            pitch_q       = 0;
            yaw_q         = 0;
            is_seeded     = 1'b0;
            attitude_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_GYRO_RANGE: range_500     = i_cfg_data[0];
                    CFG_ALPHA:      alpha_q15     = i_cfg_data;
                    CFG_DEADBAND:   deadband_x100 = i_cfg_data[11:0];
                    CFG_READY:      ready_x100    = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            // compare before pushing so a same-edge transfer never matches itself
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (attitude_q.size() == 0) begin
                    $error("result transfer with no sample outstanding");
                    fails++;
                end else begin
                    e = attitude_q.pop_front();
                    compare_field("roll_tenths", e.roll, i_roll_tenths);
                    compare_field("pitch_tenths", e.pitch, i_pitch_tenths);
                    compare_field("yaw_x10", e.yaw, i_yaw_x10);
                    compare_field("yaw_rate_x10", e.rate10, i_yaw_rate_x10);
                    compare_field("yaw_rate_x100", e.rate100, i_yaw_rate_x100);
                    compare_field("drift_x100", 16'(e.drift), 16'(i_drift_x100));
                    compare_field("yaw_settled", 16'(e.ready), 16'(i_yaw_settled));
                    compare_field("yaw_quiet", 16'(e.still), 16'(i_yaw_quiet));
                end
            end
            if (i_in_valid && !i_in_stall) attitude_q.push_back(predict_attitude());
        end
    end

    initial begin
        fails   = 0;
        results = 0;
    end

endmodule

>>> tb/sv/tb_imu_complementary_attitude_top.sv
// testbench top for the imu attitude filter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_imu_complementary_attitude_top;
    import imucf_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_accel_x = '0;
    logic signed [15:0] i_accel_y = '0;
    logic signed [15:0] i_accel_z = '0;
    logic signed [15:0] i_gyro_x = '0;
    logic signed [15:0] i_gyro_y = '0;
    logic signed [15:0] i_gyro_z = '0;
    logic [19:0]        i_step_us = '0;
    logic               i_zero_yaw = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_roll_tenths;
    logic signed [15:0] o_pitch_tenths;
    logic signed [15:0] o_yaw_x10;
    logic signed [15:0] o_yaw_rate_x10;
    logic signed [15:0] o_yaw_rate_x100;
    logic [14:0]        o_drift_x100;
    logic               o_yaw_settled;
    logic               o_yaw_quiet;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    int fail_count;
    int pending;
    int result_count;
    int sample_count = 0;
    int setting_count = 0;
    int hold_cycles = 0;
    bit calm = 1'b0;

    always #5 i_clk = ~i_clk;

    imu_complementary_attitude_top dut (.*);

    tb_imu_complementary_attitude_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_accel_x, .i_accel_y, .i_accel_z, .i_gyro_x, .i_gyro_y, .i_gyro_z,
        .i_step_us, .i_zero_yaw,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_roll_tenths(o_roll_tenths), .i_pitch_tenths(o_pitch_tenths),
        .i_yaw_x10(o_yaw_x10),
        .i_yaw_rate_x10(o_yaw_rate_x10), .i_yaw_rate_x100(o_yaw_rate_x100),
        .i_drift_x100(o_drift_x100), .i_yaw_settled(o_yaw_settled),
        .i_yaw_quiet(o_yaw_quiet),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // result side stalls, with a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < 14);
            end
        end
    end

    task automatic send_sample(input logic signed [15:0] ax, ay, az, gx, gy, gz,
                               input logic [19:0] dt, input logic zy);
        while (!calm && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_accel_x  <= ax;
        i_accel_y  <= ay;
        i_accel_z  <= az;
        i_gyro_x   <= gx;
        i_gyro_y   <= gy;
        i_gyro_z   <= gz;
        i_step_us  <= dt;
        i_zero_yaw <= zy;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sample_count++;
    endtask

    task automatic random_sample();
        int mode;
        logic signed [15:0] ax, ay, az, gx, gy, gz;
        logic [19:0] dt;
        mode = $urandom_range(99);
        if (mode < 70) begin
            ax = 16'($urandom_range(24000) - 12000);
            ay = 16'($urandom_range(24000) - 12000);
            az = 16'($urandom_range(4000) + 14000);
            if ($urandom_range(9) == 0) az = -az;
            gx = 16'($urandom_range(6000) - 3000);
            gy = 16'($urandom_range(6000) - 3000);
            gz = 16'($urandom_range(800) - 400);
            dt = 20'($urandom_range(20000, 1000));
        end else begin
            ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
            gx = 16'($urandom); gy = 16'($urandom); gz = 16'($urandom);
            dt = (mode < 92) ? 20'($urandom) : 20'd0;
        end
        send_sample(ax, ay, az, gx, gy, gz, dt, $urandom_range(99) < 5);
    endtask

    // all four registers in one burst while the block is idle
    task automatic write_settings(input logic [15:0] rng, alpha, dead, rdy);
        logic [15:0] vals [4];
        vals = '{rng, alpha, dead, rdy};
        for (int r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 2'(r);
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        setting_count++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_settings(16'd0, 16'd32113, 16'd30, 16'd30);

        // directed corners
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd1000, 1'b0);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd1000, 1'b0);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                    16'sd32767, 20'hFFFFF, 1'b0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                    16'sh8000, 20'hFFFFF, 1'b0);
        send_sample(-16'sd1000, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd39,
                    20'd5000, 1'b0);
        send_sample(16'sd1000, -16'sd100, -16'sd16384, 16'sd0, 16'sd0, 16'sd40,
                    20'd5000, 1'b0);
        send_sample(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd39,
                    20'd5000, 1'b0);
        send_sample(-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd40,
                    20'd5000, 1'b1);
        send_sample(16'sd500, 16'sd200, 16'sd16000, 16'sd100, -16'sd100, 16'sd3000,
                    20'd0, 1'b0);
        send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd32767,
                    20'd800000, 1'b0);
        send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd32767,
                    20'd800000, 1'b1);
        send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sh8000,
                    20'd900000, 1'b0);
        drain();

        write_settings(16'd1, 16'd32768, 16'd0, 16'd0);
        send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd32767, 16'sh8000, 16'sd0,
                    20'hFFFFF, 1'b0);
        send_sample(16'sd100, 16'sd0, -16'sd16384, 16'sh8000, 16'sd32767, 16'sd1,
                    20'hFFFFF, 1'b0);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_settings(16'd0, 16'd32113, 16'd30, 16'd30);
                1: write_settings(16'd1, 16'd0, 16'd3000, 16'd3000);
                2: write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hF000);
                3: write_settings(16'd0, 16'd40000, 16'd0, 16'd3000);
                default: write_settings(16'($urandom_range(1)), 16'($urandom),
                                        16'($urandom_range(3000)),
                                        16'($urandom_range(3000)));
            endcase
            for (int n = 0; n < 226; n++) begin
                if (ph == 1 && n == 60) calm = 1'b1;
                if (ph == 1 && n == 130) calm = 1'b0;
                if (ph == 2 && n == 50) hold_cycles = 600;
                random_sample();
            end
            drain();
        end

        $display("covered %0d samples, %0d results, %0d register settings",
                 sample_count, result_count, setting_count);
        $display("corners, seeding, yaw wrap and saturation, output hold-off");
        if (fail_count == 0) begin
            $display("** imu_complementary_attitude_top: PASSED **");
        end else begin
            $display("** imu_complementary_attitude_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("** imu_complementary_attitude_top: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/imucf_pkg.sv
hw/rtl/imucf_div.sv
hw/rtl/imucf_cordic.sv
hw/rtl/imu_complementary_attitude_top.sv
tb/sv/tb_imu_complementary_attitude_checker.sv
tb/sv/tb_imu_complementary_attitude_top.sv
